FILE: rtl/core/lphm_pkg.sv
// Package with the types, constants and hash function of the linear-probe hash map.
`timescale 1ns / 1ps

package lphm_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int PORT_BITS   = 32;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS  = $clog2(TABLE_SLOTS + 1);
  localparam int HALF_SLOTS  = TABLE_SLOTS / 2;

  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  typedef struct packed {
    mark_t  mark;
    key_t   key;
    value_t value;
  } entry_t;

  typedef struct packed {
    slot_idx_t rd_addr;
    logic      wr_en;
    slot_idx_t wr_addr;
    entry_t    wr_entry;
  } tbl_req_t;

  // The home slot is the XOR of all bytes of the key, reduced to the slot range.
  // The slot count is a power of two, so the reduction is a mask.
  function automatic slot_idx_t home_slot(input key_t k);
    logic [63:0] wide;
    logic [7:0]  fold;
    wide = 64'(k);
    fold = 8'd0;
    for (int b = 0; b < 8; b++) begin
      fold = fold ^ wide[8*b +: 8];
    end
    return SLOT_BITS'(fold % TABLE_SLOTS);
  endfunction

endpackage

FILE: rtl/core/lphm_req_if.sv
// Request channel carrying one map operation per item.
`timescale 1ns / 1ps

interface lphm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] key;
  logic [31:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink (input valid, input operation, input key, input value, output ready);
endinterface

FILE: rtl/core/lphm_rsp_if.sv
// Response channel carrying the status and read value of one operation per item.
`timescale 1ns / 1ps

interface lphm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink (input valid, input status, input read_value, output ready);
endinterface

FILE: rtl/core/linear_probe_hash_map.sv
// Top level of the linear-probe hash map: probe sequencer and slot memory.
`timescale 1ns / 1ps

// A 64-slot key/value map with open addressing and linear probing. Each request item is a
// get, set or delete and yields exactly one response item. After an item is accepted, the
// slots are visited one at a time, from the key's home slot until a matching live slot, an
// empty slot or a sweep of all 64 slots, since the slot memory has a single read port. The
// request side is not ready while an item is being probed; the result waits in an output
// register, and the next item may be accepted while it does. A finished probe holds while
// that register is still full. Slot marks are cleared at reset through per-slot valid bits,
// so no clearing pass is run.
module linear_probe_hash_map
  import lphm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lphm_req_if.sink   req,
  lphm_rsp_if.source rsp
);

  tbl_req_t tbl;
  entry_t   rd_entry;

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .tbl      (tbl),
    .rd_entry (rd_entry)
  );

  lphm_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl),
    .rd_entry (rd_entry)
  );

endmodule

FILE: rtl/core/lphm_table.sv
// Slot memory holding mark, key and value per slot, with per-slot valid bits.
`timescale 1ns / 1ps

module lphm_table
  import lphm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t req,
  output entry_t   rd_entry
);

  entry_t                 mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid;
  entry_t                 rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
    rd_q <= mem[req.rd_addr];
  end

  // A slot never written since reset reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_vld <= valid[req.rd_addr];
    end
  end

  always_comb begin
    rd_entry = rd_q;
    if (!rd_vld) begin
      rd_entry.mark = MARK_EMPTY;
    end
  end

endmodule

FILE: rtl/core/lphm_ctrl.sv
// Probe sequencer: walks the slot chain one slot a cycle and applies the operation.
`timescale 1ns / 1ps

module lphm_ctrl
  import lphm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  lphm_req_if.sink        req,
  lphm_rsp_if.source      rsp,
  output tbl_req_t        tbl,
  input  entry_t          rd_entry
);

  state_t    state, state_next;
  logic [1:0] op;
  key_t      key;
  value_t    value;
  slot_idx_t idx;
  slot_idx_t visits;
  logic      free_seen;
  slot_idx_t free_idx;
  count_t    live_count;
  logic      rsp_valid;
  status_t   rsp_status;
  value_t    rsp_value;

  logic      is_hit;
  logic      finish;
  logic      out_free;
  logic      free_ok;
  slot_idx_t free_now;
  slot_idx_t idx_inc;
  logic      commit;
  logic      advance;
  logic      count_up;
  logic      count_dn;
  status_t   res_status;
  value_t    res_value;

  assign is_hit   = (rd_entry.mark == MARK_LIVE) && (rd_entry.key == key);
  assign finish   = (rd_entry.mark == MARK_EMPTY) || is_hit ||
                    (visits == SLOT_BITS'(TABLE_SLOTS - 1));
  assign out_free = !rsp_valid || rsp.ready;
  assign free_now = free_seen ? free_idx : idx;
  // On a miss the free slot is the first non-live slot passed, or else the current
  // slot when it is not live; a sweep that meets only live slots leaves none.
  assign free_ok  = free_seen || (rd_entry.mark != MARK_LIVE);
  assign idx_inc  = (idx == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : idx + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready          = 1'b0;
    tbl.rd_addr        = idx;
    tbl.wr_en          = 1'b0;
    tbl.wr_addr        = is_hit ? idx : free_now;
    tbl.wr_entry.mark  = MARK_LIVE;
    tbl.wr_entry.key   = key;
    tbl.wr_entry.value = value;
    commit             = 1'b0;
    advance            = 1'b0;
    count_up           = 1'b0;
    count_dn           = 1'b0;
    res_status         = ST_MISSING;
    res_value          = '0;
    unique case (state)
      S_IDLE: begin
        // No item is taken while reset is held.
        req.ready   = !rst;
        tbl.rd_addr = home_slot(KEY_BITS'(req.key));
      end
      S_PROBE: begin
        if (!finish) begin
          advance     = 1'b1;
          tbl.rd_addr = idx_inc;
        end else if (out_free) begin
          commit = 1'b1;
          case (op)
            OP_GET: begin
              if (is_hit) begin
                res_status = ST_OK;
                res_value  = rd_entry.value;
              end
            end
            OP_SET: begin
              if (is_hit) begin
                tbl.wr_en  = 1'b1;
                res_status = ST_OK;
              end else if (live_count >= COUNT_BITS'(HALF_SLOTS) || !free_ok) begin
                res_status = ST_FULL;
              end else begin
                tbl.wr_en  = 1'b1;
                count_up   = 1'b1;
                res_status = ST_OK;
              end
            end
            OP_DEL: begin
              if (is_hit) begin
                tbl.wr_en          = 1'b1;
                tbl.wr_entry.mark  = MARK_TOMB;
                tbl.wr_entry.value = rd_entry.value;
                count_dn           = 1'b1;
                res_status         = ST_OK;
              end
            end
            default: res_status = ST_MISSING;
          endcase
        end
        // While the result register is still full the current slot is read again.
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (count_up) begin
        live_count <= live_count + 1'b1;
      end else if (count_dn && live_count != '0) begin
        live_count <= live_count - 1'b1;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op        <= req.operation;
      key       <= KEY_BITS'(req.key);
      value     <= VALUE_BITS'(req.value);
      idx       <= home_slot(KEY_BITS'(req.key));
      visits    <= '0;
      free_seen <= 1'b0;
    end else if (advance) begin
      idx    <= idx_inc;
      visits <= visits + 1'b1;
      if (!free_seen && rd_entry.mark != MARK_LIVE) begin
        free_seen <= 1'b1;
        free_idx  <= idx;
      end
    end
    if (commit) begin
      rsp_status <= res_status;
      rsp_value  <= res_value;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = PORT_BITS'(rsp_value);

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the linear-probe hash map with a scoreboard and random stalls.
`timescale 1ns / 1ps

module tb;
  import lphm_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RAND_ITEMS  = 450;
  localparam int         HOLD_CYCLES = 80;
  localparam int         DRAIN_WAIT  = 100;
  localparam int         LIMIT       = 600000;

  typedef struct packed {
    logic [1:0] operation;
    key_t       key;
    value_t     value;
  } map_req_t;

  typedef struct packed {
    status_t status;
    value_t  read_value;
  } map_rsp_t;

  logic clk;
  logic rst;

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  linear_probe_hash_map u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table.
  mark_t       tbl_mark [TABLE_SLOTS];
  key_t        tbl_key  [TABLE_SLOTS];
  value_t      tbl_val  [TABLE_SLOTS];
  int unsigned live_n;

  map_req_t req_backlog [$];
  map_rsp_t pending_rsp [$];
  key_t     set_keys [$];

  int total_items = 0;
  int n_accepted  = 0;
  int err_count   = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int send_idle;
  int recv_idle;
  bit hold_done;
  bit req_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic slot_idx_t key_home(input key_t k);
    logic [7:0] fold;
    fold = k[7:0] ^ k[15:8] ^ k[23:16] ^ k[31:24];
    return fold[SLOT_BITS-1:0];
  endfunction

  // Applies one operation to the shadow table and returns the response it should give.
  function automatic map_rsp_t map_apply(input logic [1:0] op, input key_t k, input value_t v);
    map_rsp_t  res;
    int        hit;
    int        spare;
    slot_idx_t idx;
    res.status     = ST_MISSING;
    res.read_value = '0;
    hit   = -1;
    spare = -1;
    idx   = key_home(k);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (tbl_mark[idx] == MARK_EMPTY) begin
        if (spare < 0) spare = idx;
        break;
      end
      if (tbl_mark[idx] == MARK_LIVE && tbl_key[idx] == k) begin
        hit = idx;
        break;
      end
      if (tbl_mark[idx] != MARK_LIVE && spare < 0) spare = idx;
      idx = idx + 1'b1;
    end
    case (op)
      OP_GET: begin
        if (hit >= 0) begin
          res.status     = ST_OK;
          res.read_value = tbl_val[hit];
        end
      end
      OP_SET: begin
        if (hit >= 0) begin
          tbl_val[hit] = v;
          res.status   = ST_OK;
        end else if (live_n >= HALF_SLOTS || spare < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_mark[spare] = MARK_LIVE;
          tbl_key[spare]  = k;
          tbl_val[spare]  = v;
          live_n          = live_n + 1;
          res.status      = ST_OK;
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          tbl_mark[hit] = MARK_TOMB;
          live_n        = live_n - 1;
          res.status    = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("mismatch at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic add_req(input logic [1:0] op, input key_t k, input value_t v);
    map_req_t r;
    r.operation = op;
    r.key       = k;
    r.value     = v;
    req_backlog.push_back(r);
    if (op == OP_SET) set_keys.push_back(k);
  endtask

  // Removes every key set so far, in random order, leaving no live entry behind.
  task automatic drain_keys();
    int j;
    while (set_keys.size() > 0) begin
      j = $urandom_range(0, set_keys.size() - 1);
      add_req(OP_DEL, set_keys[j], $urandom);
      set_keys.delete(j);
    end
  endtask

  function automatic key_t key_with_home(input int unsigned h);
    logic [31:0] k;
    k      = $urandom;
    k[7:0] = k[15:8] ^ k[23:16] ^ k[31:24] ^ {k[7:6], 6'(h)};
    return k;
  endfunction

  function automatic key_t fresh_key();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    key_t ka, kb, kc, kb2, k;
    key_t evens [$];
    key_t odds [$];
    int   target;
    int   len;
    int   cluster;
    int   r;
    bit   sweep_done;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = '0;
    req_ch.key       = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    live_n           = 0;
    foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;

    // Directed part: empty table, extreme keys and values, update, unused code,
    // a collision chain with a tombstone in the middle and its reuse.
    add_req(OP_GET, '0, '1);
    add_req(OP_DEL, '0, '0);
    add_req(OP_SET, '0, '0);
    add_req(OP_SET, '1, '1);
    add_req(OP_GET, '0, '1);
    add_req(OP_GET, '1, '0);
    add_req(OP_SET, '0, 32'hA5A5_A5A5);
    add_req(OP_GET, '0, '0);
    add_req(OP_UNUSED, '0, '1);
    add_req(OP_GET, '0, '0);
    ka  = key_with_home(9);
    kb  = key_with_home(9);
    kc  = key_with_home(9);
    kb2 = key_with_home(9);
    add_req(OP_SET, ka, $urandom);
    add_req(OP_SET, kb, $urandom);
    add_req(OP_SET, kc, $urandom);
    add_req(OP_DEL, kb, $urandom);
    add_req(OP_GET, kc, $urandom);
    add_req(OP_DEL, kb, $urandom);
    add_req(OP_SET, kb2, $urandom);
    add_req(OP_GET, kb2, $urandom);
    add_req(OP_DEL, '0, '0);
    add_req(OP_DEL, '1, '1);
    add_req(OP_GET, ka, $urandom);

    target     = req_backlog.size() + RAND_ITEMS;
    sweep_done = 1'b0;
    while (req_backlog.size() < target) begin
      if (!sweep_done && req_backlog.size() >= target - 300) begin
        // Occupy every slot: live keys on odd homes, tombstones on even ones.
        drain_keys();
        for (int h = 0; h < TABLE_SLOTS; h += 2) evens.push_back(key_with_home(h));
        for (int h = 1; h < TABLE_SLOTS; h += 2) odds.push_back(key_with_home(h));
        foreach (evens[i]) add_req(OP_SET, evens[i], $urandom);
        foreach (evens[i]) add_req(OP_DEL, evens[i], $urandom);
        foreach (odds[i]) add_req(OP_SET, odds[i], $urandom);
        repeat (4) add_req(OP_GET, fresh_key(), $urandom);
        repeat (2) add_req(OP_SET, fresh_key(), $urandom);
        for (int i = 0; i < 4; i++) add_req(OP_GET, odds[$urandom_range(0, 31)], $urandom);
        add_req(OP_DEL, odds[3], $urandom);
        add_req(OP_DEL, odds[20], $urandom);
        repeat (2) add_req(OP_SET, fresh_key(), $urandom);
        add_req(OP_GET, odds[20], $urandom);
        sweep_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            len = $urandom_range(10, 30);
            repeat (len) begin
              if (set_keys.size() > 0 && $urandom_range(0, 9) < 7)
                k = set_keys[$urandom_range(0, set_keys.size() - 1)];
              else
                k = fresh_key();
              r = $urandom_range(0, 99);
              if (r < 35)      add_req(OP_SET, k, $urandom);
              else if (r < 65) add_req(OP_GET, k, $urandom);
              else if (r < 93) add_req(OP_DEL, k, $urandom);
              else             add_req(OP_UNUSED, k, $urandom);
            end
          end
          5, 6, 7: begin
            // A burst of new keys, partly clustered to build long chains and reach the
            // half-full limit.
            cluster = $urandom_range(0, TABLE_SLOTS - 1);
            len     = $urandom_range(10, 40);
            repeat (len) begin
              if ($urandom_range(0, 9) < 3)
                k = key_with_home((cluster + $urandom_range(0, 3)) % TABLE_SLOTS);
              else
                k = fresh_key();
              add_req(OP_SET, k, $urandom);
            end
          end
          8: drain_keys();
          default: begin
            len = $urandom_range(3, 8);
            repeat (len) begin
              r = $urandom_range(0, 2);
              if (r == 0)      add_req(OP_UNUSED, $urandom, $urandom);
              else if (r == 1) add_req(OP_GET, fresh_key(), $urandom);
              else             add_req(OP_DEL, fresh_key(), $urandom);
            end
          end
        endcase
      end
    end
    total_items = req_backlog.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < total_items) @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Idling plan by progress: sender light and receiver heavy, then swapped, then none.
  always @* begin
    if (n_accepted < total_items / 3) begin
      send_idle = 21;
      recv_idle = 70;
    end else if (n_accepted < 2 * total_items / 3) begin
      send_idle = 70;
      recv_idle = 21;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // One long receiver hold-off, so that the output register fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= total_items / 6) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin : drive_req
    map_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        nxt = req_backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= nxt.operation;
        req_ch.key       <= nxt.key;
        req_ch.value     <= nxt.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : score
    map_rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected response, status %0d value %h",
                                    rsp_ch.status, rsp_ch.read_value));
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_ch.status, want.status));
          if (rsp_ch.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp_ch.read_value, want.read_value));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_rsp.push_back(map_apply(req_ch.operation, req_ch.key, req_ch.value));
        n_accepted <= n_accepted + 1;
      end
    end
  end

endmodule
